[hdl/kmph_pkg.sv]
// Shared opcodes and types for the KMP prefix-match histogram block.
package kmph_pkg;

	typedef logic [2:0] opcode_t;

	localparam opcode_t OP_LOAD  = 3'd0;
	localparam opcode_t OP_TEXT  = 3'd1;
	localparam opcode_t OP_END   = 3'd2;
	localparam opcode_t OP_READ  = 3'd3;
	localparam opcode_t OP_CLEAR = 3'd4;

endpackage

[hdl/kmph_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module kmph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/kmp_prefix_match_histogram.sv]
// KMP matcher over a byte stream with a saturating histogram of fallback lengths.
//
// One word in, one word out. The pattern store, border table and histogram sit
// in three RAMs with registered read ports, and a sequencer walks them: a read
// count reads the histogram and then answers; a pattern load walks the border
// chain (border read, pattern read, evaluate) and then writes; a text byte or
// end of text reads the table, then evaluates and writes back the bumped count,
// once per visited length; an end of text at length zero answers on acceptance.
// The table walk is what bounds the rate. The result sits in an output register;
// the next word can be taken in the cycle that result is taken. After reset and
// after a clear-all word, a clearing pass over all MAX_PATTERN+1 entries zeroes
// the histogram, during which no word is taken. Border entries are only read at
// or below the loaded length, so they need no clear.
module kmp_prefix_match_histogram
	import kmph_pkg::*;
#(
	parameter int MAX_PATTERN = 256,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [8:0]  length_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] count,
	output logic [8:0]  match_length,
	output logic [8:0]  pattern_length,
	output logic        error
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int PW = $clog2(MAX_PATTERN);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_TRD   = 4'd2;
	localparam logic [3:0] S_TEV   = 4'd3;
	localparam logic [3:0] S_LRB   = 4'd4;
	localparam logic [3:0] S_LRP   = 4'd5;
	localparam logic [3:0] S_LEV   = 4'd6;
	localparam logic [3:0] S_LWR   = 4'd7;
	localparam logic [3:0] S_RD    = 4'd8;

	logic [3:0]            state_q;
	logic [LW-1:0]         clr_q;
	logic [LW-1:0]         len_q;
	logic [LW-1:0]         ml_q;
	logic [LW-1:0]         ll_q;
	logic [LW-1:0]         b_q;
	logic [LW-1:0]         bval_q;
	logic [7:0]            byte_q;
	logic                  end_q;
	logic                  out_valid_q;
	logic [31:0]           count_q;
	logic                  err_q;

	logic                  accept;
	logic                  ext;
	logic                  done;
	logic [PW-1:0]         pat_raddr;
	logic [LW-1:0]         brd_raddr;
	logic [LW-1:0]         cnt_raddr;
	logic [7:0]            pat_rdata;
	logic [LW-1:0]         brd_rdata;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic                  cnt_we;
	logic [LW-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [COUNT_BITS-1:0] cnt_sat;
	logic                  lwr;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign out_valid      = out_valid_q;
	assign count          = count_q;
	assign error          = err_q;
	assign match_length   = 9'(ml_q);
	assign pattern_length = 9'(ll_q);

	// next text byte extends the current match
	assign ext = (len_q < ll_q) && (pat_rdata == byte_q);

	// saturating increment of the fetched count
	assign cnt_sat = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;

	// result word completes this cycle
	always_comb begin
		done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_LOAD:  done = (ll_q >= LW'(MAX_PATTERN));
						OP_TEXT:  done = 1'b0;
						OP_END:   done = (ml_q == '0);
						OP_READ:  done = (int'(length_index) > MAX_PATTERN);
						OP_CLEAR: done = 1'b1;
						default:  done = 1'b1;
					endcase
				end
			end
			S_TEV: begin
				done = end_q ? (brd_rdata == '0) : (ext || (len_q == '0));
			end
			S_LWR:   done = 1'b1;
			S_RD:    done = 1'b1;
			default: done = 1'b0;
		endcase
	end

	// read addresses by phase
	always_comb begin
		pat_raddr = PW'(len_q);
		brd_raddr = len_q;
		cnt_raddr = len_q;
		if (state_q == S_IDLE) begin
			cnt_raddr = LW'(length_index);
		end
		if (state_q == S_LRP) begin
			pat_raddr = PW'(brd_rdata);
		end
	end

	// histogram writes: clearing pass or bump of the length being left
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = len_q;
		cnt_wdata = cnt_sat;
		if (state_q == S_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else if (state_q == S_TEV) begin
			cnt_we = end_q || !ext;
		end
	end

	assign lwr = (state_q == S_LWR);

	kmph_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat (
		.clk   (clk),
		.we    (lwr),
		.waddr (PW'(ll_q)),
		.wdata (byte_q),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	kmph_ram #(.WIDTH(LW), .DEPTH(MAX_PATTERN + 1)) u_brd (
		.clk   (clk),
		.we    (lwr),
		.waddr (ll_q + 1'b1),
		.wdata (bval_q),
		.raddr (brd_raddr),
		.rdata (brd_rdata)
	);

	kmph_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_PATTERN + 1)) u_cnt (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			len_q       <= '0;
			ml_q        <= '0;
			ll_q        <= '0;
			b_q         <= '0;
			bval_q      <= '0;
			byte_q      <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			err_q       <= 1'b0;
		end else begin
			out_valid_q <= done || (out_valid_q && out_stall);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LW'(MAX_PATTERN)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						byte_q  <= data_byte;
						count_q <= '0;
						err_q   <= 1'b0;
						case (opcode)
							OP_LOAD: begin
								if (ll_q >= LW'(MAX_PATTERN)) begin
									err_q <= 1'b1;
								end else if (ll_q == '0) begin
									bval_q  <= '0;
									state_q <= S_LWR;
								end else begin
									len_q   <= ll_q;
									state_q <= S_LRB;
								end
							end
							OP_TEXT: begin
								len_q   <= ml_q;
								end_q   <= 1'b0;
								state_q <= S_TRD;
							end
							OP_END: begin
								if (ml_q != '0) begin
									len_q   <= ml_q;
									end_q   <= 1'b1;
									state_q <= S_TRD;
								end
							end
							OP_READ: begin
								if (int'(length_index) > MAX_PATTERN) begin
									err_q <= 1'b1;
								end else begin
									state_q <= S_RD;
								end
							end
							OP_CLEAR: begin
								ml_q    <= '0;
								ll_q    <= '0;
								state_q <= S_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				S_TRD: begin
					state_q <= S_TEV;
				end
				S_TEV: begin
					// leave len_q (bumped by the write port) or extend the match
					if (end_q) begin
						if (brd_rdata == '0) begin
							ml_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							len_q   <= brd_rdata;
							state_q <= S_TRD;
						end
					end else if (ext) begin
						ml_q    <= len_q + 1'b1;
						state_q <= S_IDLE;
					end else if (len_q != '0) begin
						len_q   <= brd_rdata;
						state_q <= S_TRD;
					end else begin
						ml_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				S_LRB: begin
					state_q <= S_LRP;
				end
				S_LRP: begin
					b_q     <= brd_rdata;
					state_q <= S_LEV;
				end
				S_LEV: begin
					// border chain step for the new pattern byte
					if (pat_rdata == byte_q) begin
						bval_q  <= b_q + 1'b1;
						state_q <= S_LWR;
					end else if (b_q == '0) begin
						bval_q  <= '0;
						state_q <= S_LWR;
					end else begin
						len_q   <= b_q;
						state_q <= S_LRB;
					end
				end
				S_LWR: begin
					ll_q    <= ll_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_RD: begin
					count_q <= 32'(cnt_rdata);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
